@@ hw/rtl/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Item, result and line-state types, mode codes and register map.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAG_BITS   = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 3;
    localparam int COLOR_BITS = 24;
    localparam int CLIP_BITS  = 16;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [CLIP_BITS-1:0] CLIP_RESET = 16'sd1250;

    // Word index of a register, taken from paddr[2].
    localparam logic REG_CLIP_Y_LIMIT = 1'b0;

    localparam logic [1:0] MODE_MAP  = 2'd0;
    localparam logic [1:0] MODE_MENU = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [MAG_BITS-1:0]   mag_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;
    typedef logic        [COLOR_BITS-1:0] color_t;
    typedef logic signed [CLIP_BITS-1:0]  clip_t;

    typedef struct packed {
        logic [1:0] mode;
        coord_t     start_x;
        coord_t     start_y;
        coord_t     end_x;
        coord_t     end_y;
        color_t     pixel_color;
    } item_t;

    typedef struct packed {
        logic   draw;
        coord_t out_x;
        coord_t out_y;
        color_t out_color;
        logic   last;
    } result_t;

    typedef struct packed {
        logic   line_active;
        logic   menu_kind;
        coord_t cur_x;
        coord_t cur_y;
        coord_t target_x;
        coord_t target_y;
        mag_t   abs_dx;
        mag_t   abs_dy;
        err_t   step_error;
        logic   x_dir_neg;
        logic   y_dir_neg;
        mag_t   steps_left;
        color_t line_color;
    } line_state_t;

endpackage

@@ hw/rtl/lr_cfg.sv @@
// ----------------------------------------------------------------------------
// lr_cfg: configuration register block
// APB-style slave holding the clip limit for map lines.
// ----------------------------------------------------------------------------
module lr_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lr_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [lr_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [lr_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                 pready,
    output lr_pkg::clip_t                        clip_y_limit
);

    lr_pkg::clip_t clip_reg;
    lr_pkg::clip_t clip_next;
    logic          word_idx;

    assign word_idx = paddr[2];
    assign pready   = 1'b1;

    always_comb
    begin
        clip_next = clip_reg;
        if (psel && penable && pwrite && word_idx == lr_pkg::REG_CLIP_Y_LIMIT)
        begin
            clip_next = lr_pkg::clip_t'(pwdata[lr_pkg::CLIP_BITS-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= lr_pkg::CLIP_RESET;
        end
        else
        begin
            clip_reg <= clip_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (word_idx == lr_pkg::REG_CLIP_Y_LIMIT)
        begin
            prdata = {{(lr_pkg::APB_DATA_BITS - lr_pkg::CLIP_BITS){clip_reg[lr_pkg::CLIP_BITS-1]}},
                      clip_reg};
        end
    end

    assign clip_y_limit = clip_reg;

endmodule

@@ hw/rtl/lr_step.sv @@
// ----------------------------------------------------------------------------
// lr_step: one Bresenham step
// Combinational next-state and result logic for one start or tick item.
// ----------------------------------------------------------------------------
module lr_step
(
    input  lr_pkg::item_t       item,
    input  lr_pkg::line_state_t st,
    input  lr_pkg::clip_t       clip_y_limit,
    output lr_pkg::line_state_t st_next,
    output lr_pkg::result_t     res,
    output logic                has_result
);

    localparam int W2 = lr_pkg::ERR_BITS + 1;

    logic signed [lr_pkg::MAG_BITS-1:0] dx;
    logic signed [lr_pkg::MAG_BITS-1:0] dy;
    lr_pkg::mag_t                       adx;
    lr_pkg::mag_t                       ady;

    logic signed [W2-1:0] err2_a;
    logic signed [W2-1:0] err2_b;
    logic signed [W2-1:0] neg_ady;
    logic signed [W2-1:0] pos_adx;
    logic                 step_x;
    logic                 step_y;
    lr_pkg::err_t         err_a;
    lr_pkg::err_t         err_b;
    lr_pkg::coord_t       x_adv;
    lr_pkg::coord_t       y_adv;
    logic                 at_end;
    logic                 fin;

    // Deltas of a start item, one bit wider than the coordinates.
    assign dx  = $signed({item.end_x[lr_pkg::COORD_BITS-1], item.end_x})
               - $signed({item.start_x[lr_pkg::COORD_BITS-1], item.start_x});
    assign dy  = $signed({item.end_y[lr_pkg::COORD_BITS-1], item.end_y})
               - $signed({item.start_y[lr_pkg::COORD_BITS-1], item.start_y});
    assign adx = dx[lr_pkg::MAG_BITS-1] ? lr_pkg::mag_t'(-dx) : lr_pkg::mag_t'(dx);
    assign ady = dy[lr_pkg::MAG_BITS-1] ? lr_pkg::mag_t'(-dy) : lr_pkg::mag_t'(dy);

    // Error update: the y test sees the error after the x test has acted.
    assign neg_ady = -$signed({{(W2 - lr_pkg::MAG_BITS){1'b0}}, st.abs_dy});
    assign pos_adx =  $signed({{(W2 - lr_pkg::MAG_BITS){1'b0}}, st.abs_dx});
    assign err2_a  = $signed({st.step_error, 1'b0});
    assign step_x  = err2_a > neg_ady;
    assign err_a   = step_x
                   ? st.step_error - lr_pkg::err_t'({1'b0, st.abs_dy})
                   : st.step_error;
    assign err2_b  = $signed({err_a, 1'b0});
    assign step_y  = err2_b < pos_adx;
    assign err_b   = step_y ? err_a + lr_pkg::err_t'({1'b0, st.abs_dx}) : err_a;

    assign x_adv = step_x ? (st.x_dir_neg ? st.cur_x - 1'b1 : st.cur_x + 1'b1) : st.cur_x;
    assign y_adv = step_y ? (st.y_dir_neg ? st.cur_y - 1'b1 : st.cur_y + 1'b1) : st.cur_y;

    assign at_end = (st.cur_x == st.target_x) && (st.cur_y == st.target_y);

    always_comb
    begin
        st_next    = st;
        res        = '0;
        has_result = 1'b0;
        fin        = 1'b0;
        unique case (item.mode)
            lr_pkg::MODE_MAP, lr_pkg::MODE_MENU:
            begin
                st_next.cur_x      = item.start_x;
                st_next.cur_y      = item.start_y;
                st_next.target_x   = item.end_x;
                st_next.target_y   = item.end_y;
                st_next.abs_dx     = adx;
                st_next.abs_dy     = ady;
                st_next.x_dir_neg  = !(item.end_x > item.start_x);
                st_next.y_dir_neg  = !(item.end_y > item.start_y);
                st_next.step_error = lr_pkg::err_t'({1'b0, adx}) - lr_pkg::err_t'({1'b0, ady});
                st_next.line_color = item.pixel_color;
                st_next.menu_kind  = (item.mode == lr_pkg::MODE_MENU);
                st_next.steps_left = (adx > ady) ? adx : ady;
                st_next.line_active = (item.mode == lr_pkg::MODE_MENU)
                                    || (adx != '0) || (ady != '0);
            end
            lr_pkg::MODE_TICK:
            begin
                has_result = 1'b1;
                if (!st.line_active)
                begin
                    res.last = 1'b1;
                end
                else
                begin
                    res.out_x     = st.cur_x;
                    res.out_y     = st.cur_y;
                    res.out_color = st.line_color;
                    if (st.menu_kind)
                    begin
                        res.draw = 1'b1;
                        fin      = at_end;
                        if (!at_end)
                        begin
                            st_next.cur_x      = x_adv;
                            st_next.cur_y      = y_adv;
                            st_next.step_error = err_b;
                        end
                    end
                    else
                    begin
                        res.draw           = st.cur_y < clip_y_limit;
                        st_next.cur_x      = x_adv;
                        st_next.cur_y      = y_adv;
                        st_next.step_error = err_b;
                        st_next.steps_left = st.steps_left - 1'b1;
                        fin                = st.steps_left <= lr_pkg::mag_t'(1);
                    end
                    res.last = fin;
                    if (fin)
                    begin
                        st_next.line_active = 1'b0;
                    end
                end
            end
            lr_pkg::MODE_NONE:
            begin
                has_result = 1'b0;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line generator
// Start items load a line, tick items step it and return one pixel each.
// ----------------------------------------------------------------------------
// The block takes one item per clock while item_stall is low and returns one
// result per tick item, through the input register and the result register.
// The rate of one item per cycle is set by the single Bresenham step unit,
// which does the x and y error updates of one step between the input
// register and the result register. A start item (map or menu) loads the
// line and returns nothing; a tick item returns the pixel at the current
// position and then moves one step. Map lines run max(|dx|,|dy|) ticks, leave
// out the endpoint and mark pixels whose y is not below clip_y_limit as not
// drawn. Menu lines end on the endpoint and are never clipped. A tick with no
// active line returns a result with draw low and last high. Mode three is
// ignored. clip_y_limit sits at byte address 0 of the APB port and should be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module line_rasterizer
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  lr_pkg::item_t                        item,

    output logic                                 result_valid,
    input  logic                                 result_stall,
    output lr_pkg::result_t                      result,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lr_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [lr_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [lr_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                 pready
);

    // Input stage: the accepted beat waits here for the step unit.
    logic                in_valid_reg;
    logic                in_valid_next;
    lr_pkg::item_t       in_item_reg;
    lr_pkg::item_t       in_item_next;

    // Line state, updated by every start and tick beat.
    lr_pkg::line_state_t line_reg;
    lr_pkg::line_state_t line_next;

    // Result stage.
    logic                out_valid_reg;
    logic                out_valid_next;
    lr_pkg::result_t     out_result_reg;
    lr_pkg::result_t     out_result_next;

    lr_pkg::line_state_t step_state;
    lr_pkg::result_t     step_result;
    logic                step_has_result;
    lr_pkg::clip_t       clip_y_limit;

    logic                out_room;
    logic                step_fire;
    logic                item_take;

    lr_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .clip_y_limit (clip_y_limit)
    );

    lr_step u_step
    (
        .item         (in_item_reg),
        .st           (line_reg),
        .clip_y_limit (clip_y_limit),
        .st_next      (step_state),
        .res          (step_result),
        .has_result   (step_has_result)
    );

    // A start beat never needs the result stage, so it moves on even while
    // a finished result is held by a stalled consumer.
    assign out_room   = !out_valid_reg || !result_stall;
    assign step_fire  = in_valid_reg && (!step_has_result || out_room);
    assign item_stall = in_valid_reg && !step_fire;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (item_take)
        begin
            in_valid_next = 1'b1;
            in_item_next  = item;
        end
        else if (step_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        line_next = line_reg;
        if (step_fire)
        begin
            line_next = step_state;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (step_fire && step_has_result)
        begin
            out_valid_next  = 1'b1;
            out_result_next = step_result;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            line_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            line_reg      <= line_next;
        end
    end

    // Beat payloads need no reset: each is only read while its valid bit
    // is set.
    always_ff @(posedge clk)
    begin
        in_item_reg    <= in_item_next;
        out_result_reg <= out_result_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

endmodule

@@ hw/rtl/lr_checker.sv @@
// ----------------------------------------------------------------------------
// lr_checker: port-level assertions for the line rasterizer
// Checks the result hold, input back-pressure, known handshakes and APB ready.
// ----------------------------------------------------------------------------
module lr_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            item_valid,
    input logic            item_stall,
    input logic            result_valid,
    input logic            result_stall,
    input lr_pkg::result_t result,
    input logic            pready
);

    // A stalled result stays offered and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // The input side is only held back while a result is waiting.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled with no pending result");

    // The item handshake and result_valid are always known once out of reset.
    a_known_handshake: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({item_valid, item_stall, result_valid}))
        else $error("handshake signal unknown");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind line_rasterizer lr_checker u_lr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .pready       (pready)
);
